// ===== sv/eopc_pkg.sv =====
package eopc_pkg;

  // fixed field widths
  localparam int VAL_W = 11;
  localparam int PAIR_W = 19;
  localparam int VAL_RANGE = 1 << VAL_W;

  // generation tag kept beside each histogram count
  localparam int EPOCH_W = 8;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
  localparam logic [EPOCH_W-1:0] EPOCH_LAST = {EPOCH_W{1'b1}};
  localparam logic [EPOCH_W-1:0] EPOCH_NONE = '0;

  localparam int DEF_MAX_LEN = 1024;

endpackage

// ===== sv/equal_offset_pair_counter.sv =====
// channel  | signals                          | direction | word
// ---------+----------------------------------+-----------+--------------------------
// item     | item_valid item_ready value last | in        | one array element
// result   | result_valid result_ready        | out       | pair_count, overflow
//          | pair_count overflow              |           | (one per array)
//
// one element per cycle unless clearing or an untaken result stalls it: the key
// is read from the histogram ram when the word is taken and written back from
// stage two; a one-entry bypass covers equal keys back to back. the result is
// registered as the last element leaves stage two. after reset and every 255th
// array, a clearing pass sweeps all 2*MAX_LEN entries while item_ready stays low.
// a result that is not taken holds the last element in the second stage and
// stops new words; earlier results do not block elements of the next array.
module equal_offset_pair_counter
  import eopc_pkg::*;
#(
  parameter int MAX_LEN = DEF_MAX_LEN
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  logic [VAL_W-1:0]  value,
  input  logic              last,
  output logic              result_valid,
  input  logic              result_ready,
  output logic [PAIR_W-1:0] pair_count,
  output logic              overflow
);

  localparam int KEY_DEPTH = 2 * MAX_LEN;
  localparam int IDX_W = $clog2(KEY_DEPTH);
  localparam int CNT_W = $clog2(MAX_LEN + 1);
  localparam int POS_W = $clog2(MAX_LEN + 1);
  localparam int ENT_W = EPOCH_W + CNT_W;
  localparam int RED_STEPS = (KEY_DEPTH >= VAL_RANGE) ? 0 :
                             $clog2((VAL_RANGE + KEY_DEPTH - 1) / KEY_DEPTH);
  localparam logic [IDX_W-1:0] IDX_TOP = IDX_W'(KEY_DEPTH - 1);

  // histogram ram: {tag, count}
  logic [ENT_W-1:0] mem [KEY_DEPTH];
  logic [ENT_W-1:0] rdata;

  logic               clearing;
  logic [IDX_W-1:0]   clear_idx;
  logic [EPOCH_W-1:0] epoch;
  logic [POS_W-1:0]   position;
  logic [IDX_W-1:0]   offset;
  logic               overflowed;
  logic [PAIR_W-1:0]  running_pairs;

  logic               s2_valid;
  logic [IDX_W-1:0]   s2_idx;
  logic               s2_last;
  logic               s2_counted;
  logic               s2_ovf;

  logic               fwd_valid;
  logic [IDX_W-1:0]   fwd_idx;
  logic [ENT_W-1:0]   fwd_ent;

  logic               in_fire;
  logic               counted;
  logic               out_free;
  logic               s2_adv;
  logic [VAL_W-1:0]   vred;
  logic [IDX_W:0]     idx_sum;
  logic [IDX_W-1:0]   idx;
  logic [ENT_W-1:0]   cur_ent;
  logic               hit;
  logic [CNT_W-1:0]   prior;
  logic [PAIR_W-1:0]  pairs_sum;

  assign out_free = !result_valid || result_ready;
  assign s2_adv = s2_valid && !(s2_last && !out_free);
  assign item_ready = !clearing &&
                      !(s2_valid && s2_last && (!out_free || epoch == EPOCH_LAST));
  assign in_fire = item_valid && item_ready;
  assign counted = position < POS_W'(MAX_LEN);

  // key index = (value - position - 1) mod 2*MAX_LEN, offset holds -(position + 1)
  always_comb begin
    vred = value;
    for (int k = RED_STEPS - 1; k >= 0; k--) begin
      if (32'(vred) >= 32'(KEY_DEPTH << k)) begin
        vred = vred - VAL_W'(KEY_DEPTH << k);
      end
    end
    idx_sum = (IDX_W + 1)'(vred) + {1'b0, offset};
    if (idx_sum >= (IDX_W + 1)'(KEY_DEPTH)) begin
      idx_sum = idx_sum - (IDX_W + 1)'(KEY_DEPTH);
    end
    idx = idx_sum[IDX_W-1:0];
  end

  // bypass the write that landed in the same cycle as this read
  always_comb begin
    cur_ent = (fwd_valid && fwd_idx == s2_idx) ? fwd_ent : rdata;
    hit = cur_ent[ENT_W-1 -: EPOCH_W] == epoch;
    prior = hit ? cur_ent[CNT_W-1:0] : '0;
    pairs_sum = s2_counted ? running_pairs + PAIR_W'(prior) : running_pairs;
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      rdata <= mem[idx];
    end
    if (clearing) begin
      mem[clear_idx] <= {EPOCH_NONE, CNT_W'(0)};
    end else if (s2_adv && s2_counted) begin
      mem[s2_idx] <= {epoch, prior + CNT_W'(1)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clear_idx <= '0;
      epoch <= EPOCH_FIRST;
    end else if (clearing) begin
      clear_idx <= clear_idx + IDX_W'(1);
      if (clear_idx == IDX_TOP) begin
        clearing <= 1'b0;
      end
    end else if (s2_adv && s2_last) begin
      if (epoch == EPOCH_LAST) begin
        clearing <= 1'b1;
        clear_idx <= '0;
        epoch <= EPOCH_FIRST;
      end else begin
        epoch <= epoch + EPOCH_W'(1);
      end
    end
  end

  // element count and key offset move when the word is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
      offset <= IDX_TOP;
      overflowed <= 1'b0;
    end else if (in_fire) begin
      if (last) begin
        position <= '0;
        offset <= IDX_TOP;
        overflowed <= 1'b0;
      end else if (counted) begin
        position <= position + POS_W'(1);
        offset <= offset - IDX_W'(1);
      end else begin
        overflowed <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (in_fire) begin
      s2_valid <= 1'b1;
    end else if (s2_adv) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s2_idx <= idx;
      s2_last <= last;
      s2_counted <= counted;
      s2_ovf <= overflowed || !counted;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (clearing) begin
      fwd_valid <= 1'b0;
    end else if (s2_adv && s2_counted) begin
      fwd_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv && s2_counted) begin
      fwd_idx <= s2_idx;
      fwd_ent <= {epoch, prior + CNT_W'(1)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_pairs <= '0;
    end else if (s2_adv) begin
      running_pairs <= s2_last ? '0 : pairs_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s2_adv && s2_last) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv && s2_last) begin
      pair_count <= pairs_sum;
      overflow <= s2_ovf;
    end
  end

`ifndef SYNTH
  a_no_take_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !item_ready)
    else $error("word taken during clearing pass");

  a_stage_empty_when_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s2_valid)
    else $error("ram sweep overlaps a pending write back");

  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    (s2_adv && s2_last) |=> result_valid)
    else $error("last element left without a result");

  a_prior_bounded: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && s2_counted) |-> (32'(prior) < MAX_LEN))
    else $error("key count exceeds elements seen");

  a_epoch_live: assert property (@(posedge clk) disable iff (rst)
    epoch != EPOCH_NONE)
    else $error("current tag equals cleared tag");
`endif

endmodule

// ===== bench/equal_offset_pair_counter_tb.sv =====
`timescale 1ns / 100ps

module equal_offset_pair_counter_tb;
  import eopc_pkg::*;

  localparam int MAX_LEN = DEF_MAX_LEN;
  localparam int KEY_DEPTH = 2 * MAX_LEN;
  localparam int IDLE_LIMIT = 12000;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic [PAIR_W-1:0] pairs;
    logic              ovf;
  } array_result_t;

  // tracks the key histogram of the open array and queues the total per array
  class pair_scoreboard;
    int unsigned       elem_pos;
    logic [19:0]       pair_total = '0;
    logic              dropped = 1'b0;
    bit                key_seen [KEY_DEPTH];
    logic [VAL_W-1:0]  key_tally [KEY_DEPTH];
    array_result_t     expected_results [$];
    int                errors;

    function void note_word(logic [VAL_W-1:0] v, logic l);
      int unsigned slot;
      int unsigned prior;
      array_result_t r;
      if (elem_pos >= MAX_LEN) begin
        dropped = 1'b1;
      end else begin
        elem_pos++;
        slot = (int'(v) + KEY_DEPTH - elem_pos) % KEY_DEPTH;
        prior = key_seen[slot] ? int'(key_tally[slot]) : 0;
        pair_total += 20'(prior);
        key_tally[slot] = VAL_W'(prior + 1);
        key_seen[slot] = 1'b1;
      end
      if (l) begin
        r.pairs = pair_total[PAIR_W-1:0];
        r.ovf = dropped;
        expected_results = {expected_results, r};
        elem_pos = 0;
        pair_total = '0;
        dropped = 1'b0;
        foreach (key_seen[i]) key_seen[i] = 1'b0;
      end
    endfunction

    function void check_result(logic [PAIR_W-1:0] pc, logic o);
      array_result_t exp_r;
      if (expected_results.size() == 0) begin
        if (errors < 10)
          $display("unexpected result word: pair_count %0d overflow %0b", pc, o);
        errors++;
        return;
      end
      exp_r = expected_results.pop_front();
      if (pc !== exp_r.pairs || o !== exp_r.ovf) begin
        if (errors < 10)
          $display("mismatch: pair_count exp %0d got %0d, overflow exp %0b got %0b",
                   exp_r.pairs, pc, exp_r.ovf, o);
        errors++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              item_valid = 1'b0;
  logic              item_ready;
  logic [VAL_W-1:0]  value = '0;
  logic              last = 1'b0;
  logic              result_valid;
  logic              result_ready = 1'b0;
  logic [PAIR_W-1:0] pair_count;
  logic              overflow;

  pair_scoreboard sb;
  bit hold_req = 1'b0;
  int burst_left = 0;
  int words_sent = 0;
  int arrays_sent = 0;
  int idle_cycles = 0;

  equal_offset_pair_counter #(.MAX_LEN(MAX_LEN)) u_top (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .value(value),
    .last(last),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .pair_count(pair_count),
    .overflow(overflow)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_word(input logic [VAL_W-1:0] v, input logic l);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 7) == 0) burst_left = $urandom_range(60, 150);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if ($urandom_range(0, 15) == 0) gap = $urandom_range(10, 30);
      if (gap > 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    item_valid <= 1'b1;
    value <= v;
    last <= l;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    sb.note_word(v, l);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_seq(input int vals [$]);
    for (int i = 0; i < vals.size(); i++)
      send_word(VAL_W'(vals[i]), i == vals.size() - 1);
    arrays_sent++;
  endtask

  // style 0: keys from a narrow band, 1: uniform in range, 2: any 11-bit word,
  // 3: every element on key zero
  task automatic send_array(input int len, input int style);
    int k0;
    int v;
    k0 = $urandom_range(0, 40) - 20;
    for (int i = 1; i <= len; i++) begin
      case (style)
        0: begin
          v = i + k0 + $urandom_range(0, 2);
          if (v < 1 || v > MAX_LEN) v = $urandom_range(1, MAX_LEN);
        end
        1: v = $urandom_range(1, MAX_LEN);
        2: v = $urandom_range(0, VAL_RANGE - 1);
        default: v = i;
      endcase
      send_word(VAL_W'(v), i == len);
    end
    arrays_sent++;
  endtask

  // stop offering words until every result is back
  task automatic drain_pause();
    item_valid <= 1'b0;
    burst_left = 0;
    do @(negedge clk); while (sb.expected_results.size() != 0);
  endtask

  initial begin : receiver
    int mode_left;
    int ph;
    bit open;
    bit [7:0] mask;
    mode_left = 0;
    ph = 0;
    open = 1'b1;
    mask = 8'hff;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        result_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (mode_left == 0) begin
        mode_left = $urandom_range(16, 160);
        open = ($urandom_range(0, 2) == 0);
        mask = 8'($urandom);
        if (mask == 0) mask = 8'h01;
      end
      mode_left--;
      ph++;
      result_ready <= open ? 1'b1 : mask[ph % 8];
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && result_ready) sb.check_result(pair_count, overflow);
      if ((item_valid && item_ready) || (result_valid && result_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int len;
    int pick;
    int style;
    sb = new;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // single elements at the range ends and out of range
    send_seq('{1});
    send_seq('{1024});
    send_seq('{0});
    send_seq('{2047});
    // all on one key, then all on different keys
    send_seq('{1, 2, 3, 4});
    send_seq('{5, 5, 5});
    // out-of-range values landing on the same entry
    send_seq('{2047, 0});
    send_seq('{2, 3, 1, 4, 5});
    send_seq('{1024, 1});

    // short arrays keep the array count past one full tag cycle
    while (words_sent < 880 || arrays_sent < 260) begin
      pick = $urandom_range(0, 99);
      if (pick < 85) len = $urandom_range(1, 2);
      else if (pick < 98) len = $urandom_range(3, 12);
      else len = $urandom_range(13, 64);
      pick = $urandom_range(0, 9);
      style = (pick < 7) ? 0 : (pick == 7) ? 3 : (pick == 8) ? 1 : 2;
      send_array(len, style);
      if (arrays_sent == 40) hold_req = 1'b1;
      if (arrays_sent == 100 || arrays_sent == 200) drain_pause();
    end

    item_valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
